### rtl/core/lpp_pkg.sv
// ----------------------------------------------------------------------------
// lpp_pkg
// Shared types and constants for the linear partition placement block.
// ----------------------------------------------------------------------------
package lpp_pkg;

  // Configuration register widths and indexes
  localparam int TW_BITS       = 9;
  localparam int PPW_BITS      = 7;
  localparam int OFS_BITS      = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 9;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL_WORKERS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PROCS_PER_WKR = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WORKER_OFFSET = 2'd2;

  // Result field widths
  localparam int PIDX_BITS   = 6;
  localparam int WORKER_BITS = 8;
  localparam int STATUS_BITS = 2;

  localparam logic [STATUS_BITS-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_NO_WORKERS = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW   = 2'd2;

  localparam logic [WORKER_BITS-1:0] WORKER_MAX = 8'd255;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PREP,
    S_DIV,
    S_THR,
    S_READ,
    S_EVAL,
    S_ERR
  } lpp_state_e;

endpackage

### rtl/core/lpp_store.sv
// ----------------------------------------------------------------------------
// lpp_store
// Partition count memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lpp_store #(
  parameter int DEPTH     = 64,
  parameter int ADDR_BITS = 6,
  parameter int DATA_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [DATA_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [DATA_BITS-1:0] rdata_o
);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DATA_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lpp_divider.sv
// ----------------------------------------------------------------------------
// lpp_divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpp_divider #(
  parameter int NUM_BITS = 31,
  parameter int DEN_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_BITS-1:0] dividend_i,
  input  logic [DEN_BITS-1:0] divisor_i,
  output logic [NUM_BITS-1:0] quotient_o,
  output logic                done_o
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [DEN_BITS-1:0] den_q, den_d;
  logic [DEN_BITS-1:0] rem_q, rem_d;
  logic [NUM_BITS-1:0] quo_q, quo_d;
  logic [DEN_BITS:0]   trial;
  logic                fits;

  // quo_q holds the dividend bits still to shift in, then the quotient bits
  assign trial = {rem_q, quo_q[NUM_BITS-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_BITS'(NUM_BITS);
      den_d  = divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? DEN_BITS'(trial - {1'b0, den_q}) : DEN_BITS'(trial);
      quo_d = {quo_q[NUM_BITS-2:0], fits};
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

### rtl/core/linear_partition_placement.sv
// ----------------------------------------------------------------------------
// linear_partition_placement
// Loads partition work counts, then packs them in rank order onto processors
// and workers and emits one placement per partition.
// ----------------------------------------------------------------------------
// A count transaction that is not marked last is taken while the block is idle, back
// to back. The last transaction starts placement and the input stalls until its
// final result sits in the output register: checks and setup, then the
// shift-subtract divider that forms the share, then the thresholds, and for each
// stored partition a count memory read, then the packing decision, which waits
// while the output is stalled. A run with an error goes from the checks to its one
// result, loaded into the output register once the output is not stalled. The
// count memory has one write and one read port.
module linear_partition_placement #(
  parameter int MAX_PARTITIONS = 64,
  parameter int COUNT_BITS     = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [lpp_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [lpp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  // count input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [COUNT_BITS-1:0]              partition_count_i,
  input  logic                               is_last_i,
  // placement output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [lpp_pkg::PIDX_BITS-1:0]      partition_index_o,
  output logic [lpp_pkg::WORKER_BITS-1:0]    worker_o,
  output logic                               run_last_o,
  output logic [lpp_pkg::STATUS_BITS-1:0]    status_o
);

  localparam int PTR_BITS  = $clog2(MAX_PARTITIONS + 1);
  localparam int ADDR_BITS = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int TOT_BITS  = COUNT_BITS + $clog2(MAX_PARTITIONS);
  localparam int NUM_BITS  = TOT_BITS + 1;
  localparam int DEN_BITS  = lpp_pkg::TW_BITS + lpp_pkg::PPW_BITS;
  localparam int CMP_BITS  = TOT_BITS + 3;
  localparam int WSUM_BITS = lpp_pkg::TW_BITS + 1;

  // configuration registers
  logic [lpp_pkg::TW_BITS-1:0]  tw_q;
  logic [lpp_pkg::PPW_BITS-1:0] ppw_q;
  logic [lpp_pkg::OFS_BITS-1:0] ofs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q  <= lpp_pkg::TW_BITS'(1);
      ppw_q <= lpp_pkg::PPW_BITS'(1);
      ofs_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lpp_pkg::CFG_TOTAL_WORKERS: tw_q  <= cfg_wdata_i;
        lpp_pkg::CFG_PROCS_PER_WKR: ppw_q <= cfg_wdata_i[lpp_pkg::PPW_BITS-1:0];
        lpp_pkg::CFG_WORKER_OFFSET: ofs_q <= cfg_wdata_i[lpp_pkg::OFS_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic                        bad_cfg;
  logic [lpp_pkg::TW_BITS-1:0] usable;

  assign bad_cfg = (tw_q <= lpp_pkg::TW_BITS'(ofs_q)) || (ppw_q == '0);
  assign usable  = tw_q - lpp_pkg::TW_BITS'(ofs_q);

  // sequencer
  lpp_pkg::lpp_state_e state_q, state_d;

  logic in_acc, slot_free, mem_we, mem_re, div_start, div_done;
  logic out_load_walk, out_load_err, run_end;

  logic [PTR_BITS-1:0]  lp_q;
  logic [TOT_BITS-1:0]  total_q;
  logic                 ovf_q;
  logic [lpp_pkg::STATUS_BITS-1:0] err_status_q;
  logic [DEN_BITS-1:0]  denom_q;
  logic [TOT_BITS-1:0]  share_q;
  logic [CMP_BITS-1:0]  thr3_q;
  logic [PTR_BITS-1:0]  idx_q;
  logic [TOT_BITS-1:0]  work_q;
  logic [lpp_pkg::PPW_BITS-1:0] closed_q;
  logic [lpp_pkg::TW_BITS-1:0]  nw_q;

  logic [NUM_BITS-1:0]   dividend;
  logic [NUM_BITS-1:0]   quotient;
  logic [COUNT_BITS-1:0] rdata;
  logic                  run_last_w;

  assign slot_free  = !out_valid_o || !out_stall_i;
  assign run_last_w = (idx_q + PTR_BITS'(1)) == lp_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpp_pkg::S_IDLE: begin
        if (in_acc && is_last_i) state_d = lpp_pkg::S_CHECK;
      end
      lpp_pkg::S_CHECK: begin
        state_d = (ovf_q || bad_cfg) ? lpp_pkg::S_ERR : lpp_pkg::S_PREP;
      end
      lpp_pkg::S_PREP: state_d = lpp_pkg::S_DIV;
      lpp_pkg::S_DIV: begin
        if (div_done) state_d = lpp_pkg::S_THR;
      end
      lpp_pkg::S_THR:  state_d = lpp_pkg::S_READ;
      lpp_pkg::S_READ: state_d = lpp_pkg::S_EVAL;
      lpp_pkg::S_EVAL: begin
        if (slot_free) state_d = run_last_w ? lpp_pkg::S_IDLE : lpp_pkg::S_READ;
      end
      lpp_pkg::S_ERR: begin
        if (slot_free) state_d = lpp_pkg::S_IDLE;
      end
      default: state_d = lpp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q != lpp_pkg::S_IDLE);
    in_acc        = in_valid_i && (state_q == lpp_pkg::S_IDLE);
    mem_we        = in_acc && (lp_q < PTR_BITS'(MAX_PARTITIONS));
    mem_re        = (state_q == lpp_pkg::S_READ);
    div_start     = (state_q == lpp_pkg::S_PREP);
    out_load_walk = (state_q == lpp_pkg::S_EVAL) && slot_free;
    out_load_err  = (state_q == lpp_pkg::S_ERR) && slot_free;
    run_end       = out_load_err || (out_load_walk && run_last_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= lpp_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  // load side: pointer, running total and overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q    <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
    end else if (run_end) begin
      lp_q    <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
    end else if (in_acc) begin
      total_q <= total_q + TOT_BITS'(partition_count_i);
      if (mem_we) lp_q  <= lp_q + PTR_BITS'(1);
      else        ovf_q <= 1'b1;
    end
  end

  lpp_store #(
    .DEPTH     (MAX_PARTITIONS),
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (COUNT_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (lp_q[ADDR_BITS-1:0]),
    .wdata_i (partition_count_i),
    .re_i    (mem_re),
    .raddr_i (idx_q[ADDR_BITS-1:0]),
    .rdata_o (rdata)
  );

  // ceiling division: (total + denom - 1) / denom
  assign dividend = NUM_BITS'(total_q) + NUM_BITS'(denom_q) - NUM_BITS'(1);

  lpp_divider #(
    .NUM_BITS (NUM_BITS),
    .DEN_BITS (DEN_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (denom_q),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  // packing decision for one partition
  logic [TOT_BITS-1:0]          pc;
  logic [CMP_BITS-1:0]          sum_w;
  logic                         close;
  logic [lpp_pkg::PPW_BITS-1:0] closed_inc, closed_d;
  logic [lpp_pkg::TW_BITS-1:0]  nw_d;
  logic [TOT_BITS-1:0]          work_d;
  logic [WSUM_BITS-1:0]         wsum;
  logic [lpp_pkg::WORKER_BITS-1:0] worker_w;

  always_comb begin
    pc    = TOT_BITS'(rdata);
    sum_w = CMP_BITS'(work_q) + CMP_BITS'(pc);
    close = (work_q >= share_q) ||
            (((CMP_BITS'(work_q) << 2) > thr3_q) && ((sum_w << 1) > thr3_q));
    closed_inc = close ? closed_q + lpp_pkg::PPW_BITS'(1) : closed_q;
    work_d     = close ? pc : TOT_BITS'(sum_w);
    closed_d   = closed_inc;
    nw_d       = nw_q;
    // a full worker moves the walk on, held at the last usable worker
    if (closed_inc == ppw_q) begin
      closed_d = '0;
      if ((WSUM_BITS'(nw_q) + WSUM_BITS'(1)) < WSUM_BITS'(usable)) begin
        nw_d = nw_q + lpp_pkg::TW_BITS'(1);
      end
    end
    wsum     = WSUM_BITS'(nw_d) + WSUM_BITS'(ofs_q);
    worker_w = (wsum > WSUM_BITS'(lpp_pkg::WORKER_MAX)) ? lpp_pkg::WORKER_MAX
                                                        : wsum[lpp_pkg::WORKER_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lpp_pkg::S_CHECK) begin
      denom_q      <= DEN_BITS'(usable) * DEN_BITS'(ppw_q);
      err_status_q <= ovf_q ? lpp_pkg::STATUS_OVERFLOW : lpp_pkg::STATUS_NO_WORKERS;
    end
    if (div_done) share_q <= quotient[TOT_BITS-1:0];
    if (state_q == lpp_pkg::S_THR) begin
      thr3_q   <= CMP_BITS'(share_q) + (CMP_BITS'(share_q) << 1);
      idx_q    <= '0;
      work_q   <= '0;
      closed_q <= '0;
      nw_q     <= '0;
    end
    if (out_load_walk) begin
      idx_q    <= idx_q + PTR_BITS'(1);
      work_q   <= work_d;
      closed_q <= closed_d;
      nw_q     <= nw_d;
    end
  end

  // output register
  logic                               out_valid_q;
  logic [lpp_pkg::PIDX_BITS-1:0]      pidx_q;
  logic [lpp_pkg::WORKER_BITS-1:0]    worker_q;
  logic                               last_q;
  logic [lpp_pkg::STATUS_BITS-1:0]    status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load_walk || out_load_err) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load_walk) begin
      pidx_q   <= lpp_pkg::PIDX_BITS'(idx_q);
      worker_q <= worker_w;
      last_q   <= run_last_w;
      status_q <= lpp_pkg::STATUS_OK;
    end else if (out_load_err) begin
      pidx_q   <= '0;
      worker_q <= '0;
      last_q   <= 1'b1;
      status_q <= err_status_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign partition_index_o = pidx_q;
  assign worker_o          = worker_q;
  assign run_last_o        = last_q;
  assign status_o          = status_q;

endmodule

### rtl/core/lpp_checker.sv
// ----------------------------------------------------------------------------
// lpp_checker
// Port-level checks for linear_partition_placement, bound to the top level.
// ----------------------------------------------------------------------------
module lpp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [lpp_pkg::PIDX_BITS-1:0]   partition_index_o,
  input logic [lpp_pkg::WORKER_BITS-1:0] worker_o,
  input logic                            run_last_o,
  input logic [lpp_pkg::STATUS_BITS-1:0] status_o
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(worker_o) &&
      $stable(partition_index_o) && $stable(run_last_o) && $stable(status_o))
    else $error("stalled result changed");

  // an error ends the run in a single result at index 0, worker 0
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != lpp_pkg::STATUS_OK) |->
      run_last_o && (partition_index_o == '0) && (worker_o == '0))
    else $error("malformed error result");

  // no new count is taken while a run is still being placed
  a_no_load_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> in_stall_o)
    else $error("input open during placement");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == lpp_pkg::STATUS_OK) ||
      (status_o == lpp_pkg::STATUS_NO_WORKERS) || (status_o == lpp_pkg::STATUS_OVERFLOW))
    else $error("unknown status code");

endmodule

bind linear_partition_placement lpp_checker u_lpp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .partition_index_o (partition_index_o),
  .worker_o          (worker_o),
  .run_last_o        (run_last_o),
  .status_o          (status_o)
);
